### design/fst_pkg.sv
// Shared types, constants and character-class functions for the format string tokenizer.
package fst_pkg;

    // Saturation limit of the width and precision accumulators
    localparam int NUM_BITS      = 16;
    localparam int SAT_BITS      = (NUM_BITS < 16) ? NUM_BITS : 16;
    localparam int SAT_LIMIT_INT = (1 << SAT_BITS) - 1;
    localparam logic [15:0] SAT_LIMIT = 16'(SAT_LIMIT_INT);

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // Parser modes
    typedef enum logic [3:0] {
        MODE_LIT,
        MODE_ESC,
        MODE_OCT,
        MODE_PCT,
        MODE_FLAG,
        MODE_WID,
        MODE_PREC,
        MODE_TIME,
        MODE_SKIP,
        MODE_ERR
    } parse_mode_t;

    // Token kinds
    localparam logic [2:0] TOK_LITERAL   = 3'd0;
    localparam logic [2:0] TOK_DIRECTIVE = 3'd1;
    localparam logic [2:0] TOK_FLUSH     = 3'd2;
    localparam logic [2:0] TOK_END       = 3'd3;
    localparam logic [2:0] TOK_ERROR     = 3'd4;

    // Value kinds
    localparam logic [1:0] VK_STRING = 2'd0;
    localparam logic [1:0] VK_SIGNED = 2'd1;
    localparam logic [1:0] VK_OCTAL  = 2'd2;
    localparam logic [1:0] VK_FLOAT  = 2'd3;

    // Error codes
    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_INC_ESCAPE   = 4'd1;
    localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd2;
    localparam logic [3:0] ERR_DUP_FLAG     = 4'd3;
    localparam logic [3:0] ERR_INC_SPEC     = 4'd4;
    localparam logic [3:0] ERR_BAD_SPEC     = 4'd5;
    localparam logic [3:0] ERR_INC_TIME     = 4'd6;
    localparam logic [3:0] ERR_BAD_TIME     = 4'd7;
    localparam logic [3:0] ERR_NUMERIC_FLAG = 4'd8;

    // Flag bits; the low three only make sense for numeric conversions
    localparam logic [4:0] FLAG_ALT   = 5'b00001;
    localparam logic [4:0] FLAG_ZERO  = 5'b00010;
    localparam logic [4:0] FLAG_PLUS  = 5'b00100;
    localparam logic [4:0] FLAG_SPACE = 5'b01000;
    localparam logic [4:0] FLAG_MINUS = 5'b10000;
    localparam logic [4:0] FLAG_NUMERIC = FLAG_ALT | FLAG_ZERO | FLAG_PLUS;

    // One result word
    typedef struct packed {
        logic [2:0]  token_kind;
        logic [7:0]  byte_value;
        logic [7:0]  time_letter;
        logic [4:0]  flag_mask;
        logic [15:0] field_width;
        logic        has_precision;
        logic [15:0] precision_value;
        logic [1:0]  value_kind;
        logic [3:0]  error_code;
        logic        last;
    } result_t;

    // Results of one character, up to two
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } step_out_t;

    // Result queue status towards the input stage
    typedef struct packed {
        logic room;
        logic empty;
    } fifo_status_t;

    // Flag character to its bit, zero if not a flag
    function automatic logic [4:0] flag_bit(input logic [7:0] c);
        logic [4:0] b;
        b = 5'b0;
        unique case (c)
            "#":     b = FLAG_ALT;
            "0":     b = FLAG_ZERO;
            "+":     b = FLAG_PLUS;
            " ":     b = FLAG_SPACE;
            "-":     b = FLAG_MINUS;
            default: b = 5'b0;
        endcase
        return b;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return (c >= "0") && (c <= "7");
    endfunction

    // Decimal accumulate with saturation
    function automatic logic [15:0] sat_digit(input logic [15:0] acc, input logic [7:0] c);
        logic [19:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'b0, c[3:0]};
        if (acc > SAT_LIMIT || v > {4'b0, SAT_LIMIT})
            return SAT_LIMIT;
        return v[15:0];
    endfunction

    // Conversions that take a time subletter
    function automatic logic is_time_conv(input logic [7:0] c);
        return (c == "A") || (c == "B") || (c == "W") || (c == "C") || (c == "T");
    endfunction

    // Valid time subletters
    function automatic logic is_time_letter(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        unique case (c)
            "%", "+", "@", "a", "A", "b", "B", "c", "C", "d", "D", "e", "F",
            "g", "G", "h", "H", "I", "j", "k", "l", "m", "M", "n", "p", "r",
            "R", "s", "S", "t", "T", "u", "U", "V", "w", "W", "x", "X", "y",
            "Y", "z", "Z": hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Conversions that format as a string
    function automatic logic is_str_conv(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        unique case (c)
            "a", "b", "c", "D", "f", "F", "g", "G", "h", "H", "i", "k", "M",
            "l", "n", "p", "P", "s", "t", "u", "U", "w", "y", "Y": hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Single-letter escapes; zero means not one of them
    function automatic logic [7:0] escape_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        unique case (c)
            "a":     v = 8'd7;
            "b":     v = 8'd8;
            "f":     v = 8'd12;
            "n":     v = 8'd10;
            "r":     v = 8'd13;
            "t":     v = 8'd9;
            "v":     v = 8'd11;
            "\\":    v = 8'd92;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

### design/fst_step.sv
// Parser state registers and the per-character decode logic.
module fst_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic [7:0]          ch,
    output fst_pkg::step_out_t  step
);

    fst_pkg::parse_mode_t mode_reg, mode_next;
    logic [7:0]  oct_acc_reg, oct_acc_next;
    logic [1:0]  oct_cnt_reg, oct_cnt_next;
    logic [4:0]  flags_reg, flags_next;
    logic [15:0] width_reg, width_next;
    logic        pseen_reg, pseen_next;
    logic [15:0] prec_reg, prec_next;
    logic [7:0]  conv_reg, conv_next;

    fst_pkg::result_t res [2];
    logic [1:0]  n;
    logic        do_text;
    logic        do_spec;
    logic        do_conv;
    logic        do_fin;
    logic        do_fail;
    logic [3:0]  fail_code;
    logic [7:0]  fin_tl;
    logic [1:0]  fin_vk;
    logic [4:0]  fbit;
    fst_pkg::parse_mode_t spec_mode;

    // Build a non-directive token word
    function automatic fst_pkg::result_t mk_simple(input logic [2:0] kind,
                                                   input logic [7:0] val,
                                                   input logic [3:0] err);
        fst_pkg::result_t r;
        r            = '0;
        r.token_kind = kind;
        r.byte_value = val;
        r.error_code = err;
        return r;
    endfunction

    // Decode one character
    always_comb
    begin
        mode_next    = mode_reg;
        oct_acc_next = oct_acc_reg;
        oct_cnt_next = oct_cnt_reg;
        flags_next   = flags_reg;
        width_next   = width_reg;
        pseen_next   = pseen_reg;
        prec_next    = prec_reg;
        conv_next    = conv_reg;
        res[0]       = '0;
        res[1]       = '0;
        n            = 2'd0;
        do_text      = 1'b0;
        do_spec      = 1'b0;
        do_conv      = 1'b0;
        do_fin       = 1'b0;
        do_fail      = 1'b0;
        fail_code    = fst_pkg::ERR_NONE;
        fin_tl       = 8'd0;
        fin_vk       = fst_pkg::VK_STRING;
        spec_mode    = fst_pkg::MODE_FLAG;
        fbit         = fst_pkg::flag_bit(ch);

        if (en)
        begin
            unique case (mode_reg)
                fst_pkg::MODE_ESC:
                begin
                    if (fst_pkg::is_octal(ch))
                    begin
                        oct_acc_next = {5'b0, ch[2:0]};
                        oct_cnt_next = 2'd1;
                        mode_next    = fst_pkg::MODE_OCT;
                    end
                    else if (ch == "c")
                    begin
                        res[0]    = mk_simple(fst_pkg::TOK_FLUSH, 8'd0, fst_pkg::ERR_NONE);
                        n         = 2'd1;
                        mode_next = fst_pkg::MODE_SKIP;
                    end
                    else if (ch == 8'd0)
                    begin
                        do_fail   = 1'b1;
                        fail_code = fst_pkg::ERR_INC_ESCAPE;
                    end
                    else if (fst_pkg::escape_value(ch) != 8'd0)
                    begin
                        res[0]    = mk_simple(fst_pkg::TOK_LITERAL,
                                              fst_pkg::escape_value(ch), fst_pkg::ERR_NONE);
                        n         = 2'd1;
                        mode_next = fst_pkg::MODE_LIT;
                    end
                    else
                    begin
                        do_fail   = 1'b1;
                        fail_code = fst_pkg::ERR_BAD_ESCAPE;
                    end
                end
                fst_pkg::MODE_OCT:
                begin
                    if (fst_pkg::is_octal(ch) && oct_cnt_reg == 2'd2)
                    begin
                        // third digit closes the escape
                        res[0] = mk_simple(fst_pkg::TOK_LITERAL,
                                           {oct_acc_reg[4:0], ch[2:0]}, fst_pkg::ERR_NONE);
                        n            = 2'd1;
                        oct_acc_next = 8'd0;
                        oct_cnt_next = 2'd0;
                        mode_next    = fst_pkg::MODE_LIT;
                    end
                    else if (fst_pkg::is_octal(ch))
                    begin
                        oct_acc_next = {oct_acc_reg[4:0], ch[2:0]};
                        oct_cnt_next = oct_cnt_reg + 2'd1;
                    end
                    else
                    begin
                        // short escape: emit it, then treat char as text
                        res[0] = mk_simple(fst_pkg::TOK_LITERAL, oct_acc_reg, fst_pkg::ERR_NONE);
                        n            = 2'd1;
                        oct_acc_next = 8'd0;
                        oct_cnt_next = 2'd0;
                        mode_next    = fst_pkg::MODE_LIT;
                        do_text      = 1'b1;
                    end
                end
                fst_pkg::MODE_PCT:
                begin
                    if (ch == "%")
                    begin
                        res[0]    = mk_simple(fst_pkg::TOK_LITERAL, ch, fst_pkg::ERR_NONE);
                        n         = 2'd1;
                        mode_next = fst_pkg::MODE_LIT;
                    end
                    else
                    begin
                        flags_next = 5'b0;
                        width_next = 16'd0;
                        pseen_next = 1'b0;
                        prec_next  = 16'd0;
                        conv_next  = 8'd0;
                        do_spec    = 1'b1;
                        spec_mode  = fst_pkg::MODE_FLAG;
                    end
                end
                fst_pkg::MODE_FLAG, fst_pkg::MODE_WID, fst_pkg::MODE_PREC:
                begin
                    do_spec   = 1'b1;
                    spec_mode = mode_reg;
                end
                fst_pkg::MODE_TIME:
                begin
                    if (ch == 8'd0)
                    begin
                        do_fail   = 1'b1;
                        fail_code = fst_pkg::ERR_INC_TIME;
                    end
                    else if (fst_pkg::is_time_letter(ch))
                    begin
                        do_fin = 1'b1;
                        fin_tl = ch;
                        fin_vk = fst_pkg::VK_STRING;
                    end
                    else
                    begin
                        do_fail   = 1'b1;
                        fail_code = fst_pkg::ERR_BAD_TIME;
                    end
                end
                fst_pkg::MODE_SKIP:
                begin
                    if (ch == 8'd0)
                    begin
                        res[0]    = mk_simple(fst_pkg::TOK_END, 8'd0, fst_pkg::ERR_NONE);
                        n         = 2'd1;
                        mode_next = fst_pkg::MODE_LIT;
                    end
                end
                fst_pkg::MODE_ERR:
                begin
                    if (ch == 8'd0)
                        mode_next = fst_pkg::MODE_LIT;
                end
                default:
                begin
                    do_text = 1'b1;
                end
            endcase

            // plain text character
            if (do_text)
            begin
                if (ch == 8'd0)
                begin
                    res[n[0]] = mk_simple(fst_pkg::TOK_END, 8'd0, fst_pkg::ERR_NONE);
                    n         = n + 2'd1;
                    mode_next = fst_pkg::MODE_LIT;
                end
                else if (ch == "\\")
                    mode_next = fst_pkg::MODE_ESC;
                else if (ch == "%")
                    mode_next = fst_pkg::MODE_PCT;
                else
                begin
                    res[n[0]] = mk_simple(fst_pkg::TOK_LITERAL, ch, fst_pkg::ERR_NONE);
                    n         = n + 2'd1;
                    mode_next = fst_pkg::MODE_LIT;
                end
            end

            // flags, width and precision
            if (do_spec)
            begin
                if (spec_mode == fst_pkg::MODE_FLAG && fbit != 5'b0)
                begin
                    mode_next = fst_pkg::MODE_FLAG;
                    if ((flags_next & fbit) != 5'b0)
                    begin
                        do_fail   = 1'b1;
                        fail_code = fst_pkg::ERR_DUP_FLAG;
                    end
                    else
                        flags_next = flags_next | fbit;
                end
                else if (spec_mode != fst_pkg::MODE_PREC)
                begin
                    if (fst_pkg::is_digit(ch))
                    begin
                        width_next = fst_pkg::sat_digit(width_next, ch);
                        mode_next  = fst_pkg::MODE_WID;
                    end
                    else if (ch == ".")
                    begin
                        pseen_next = 1'b1;
                        mode_next  = fst_pkg::MODE_PREC;
                    end
                    else
                        do_conv = 1'b1;
                end
                else
                begin
                    if (fst_pkg::is_digit(ch))
                        prec_next = fst_pkg::sat_digit(prec_next, ch);
                    else
                        do_conv = 1'b1;
                end
            end

            // conversion letter
            if (do_conv)
            begin
                conv_next = ch;
                if (ch == 8'd0)
                begin
                    do_fail   = 1'b1;
                    fail_code = fst_pkg::ERR_INC_SPEC;
                end
                else if (fst_pkg::is_time_conv(ch))
                    mode_next = fst_pkg::MODE_TIME;
                else if (ch == "d")
                begin
                    do_fin = 1'b1;
                    fin_vk = fst_pkg::VK_SIGNED;
                end
                else if (ch == "m")
                begin
                    do_fin = 1'b1;
                    fin_vk = fst_pkg::VK_OCTAL;
                end
                else if (ch == "S")
                begin
                    do_fin = 1'b1;
                    fin_vk = fst_pkg::VK_FLOAT;
                end
                else if (fst_pkg::is_str_conv(ch))
                begin
                    do_fin = 1'b1;
                    fin_vk = fst_pkg::VK_STRING;
                end
                else
                begin
                    do_fail   = 1'b1;
                    fail_code = fst_pkg::ERR_BAD_SPEC;
                end
            end

            // directive token, unless numeric flags on a string
            if (do_fin)
            begin
                if (fin_vk == fst_pkg::VK_STRING && (flags_next & fst_pkg::FLAG_NUMERIC) != 5'b0)
                begin
                    do_fail   = 1'b1;
                    fail_code = fst_pkg::ERR_NUMERIC_FLAG;
                end
                else
                begin
                    res[n[0]]                 = '0;
                    res[n[0]].token_kind      = fst_pkg::TOK_DIRECTIVE;
                    res[n[0]].byte_value      = conv_next;
                    res[n[0]].time_letter     = fin_tl;
                    res[n[0]].flag_mask       = flags_next;
                    res[n[0]].field_width     = width_next;
                    res[n[0]].has_precision   = pseen_next;
                    res[n[0]].precision_value = prec_next;
                    res[n[0]].value_kind      = fin_vk;
                    n         = n + 2'd1;
                    mode_next = fst_pkg::MODE_LIT;
                end
            end

            // error token; a terminator restarts at once, else skip to it
            if (do_fail)
            begin
                res[n[0]] = mk_simple(fst_pkg::TOK_ERROR, 8'd0, fail_code);
                n         = n + 2'd1;
                mode_next = (ch == 8'd0) ? fst_pkg::MODE_LIT : fst_pkg::MODE_ERR;
            end
        end

        // mark the final word of this character
        if (n == 2'd2)
            res[1].last = 1'b1;
        else if (n == 2'd1)
            res[0].last = 1'b1;
    end

    assign step.count = n;
    assign step.res0  = res[0];
    assign step.res1  = res[1];

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= fst_pkg::MODE_LIT;
            oct_acc_reg <= 8'd0;
            oct_cnt_reg <= 2'd0;
            flags_reg   <= 5'b0;
            width_reg   <= 16'd0;
            pseen_reg   <= 1'b0;
            prec_reg    <= 16'd0;
            conv_reg    <= 8'd0;
        end
        else if (en)
        begin
            mode_reg    <= mode_next;
            oct_acc_reg <= oct_acc_next;
            oct_cnt_reg <= oct_cnt_next;
            flags_reg   <= flags_next;
            width_reg   <= width_next;
            pseen_reg   <= pseen_next;
            prec_reg    <= prec_next;
            conv_reg    <= conv_next;
        end
    end

endmodule

### design/fst_out_fifo.sv
// Result queue: takes up to two words a cycle, gives one word a cycle when popped.
module fst_out_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fst_pkg::step_out_t    push,
    input  logic                  pop,
    output fst_pkg::result_t      head_word,
    output fst_pkg::fifo_status_t status
);

    fst_pkg::result_t mem_reg [fst_pkg::FIFO_DEPTH];
    logic [fst_pkg::FIFO_PTR_W-1:0] head_reg, head_next;
    logic [fst_pkg::FIFO_PTR_W-1:0] tail_reg, tail_next;
    logic [fst_pkg::FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic [fst_pkg::FIFO_PTR_W-1:0] tail_plus1;

    assign tail_plus1 = tail_reg + 1'b1;

    // Pointer and fill updates
    always_comb
    begin
        head_next = pop ? head_reg + 1'b1 : head_reg;
        tail_next = tail_reg + fst_pkg::FIFO_PTR_W'(push.count);
        cnt_next  = cnt_reg + fst_pkg::FIFO_CNT_W'(push.count)
                    - fst_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Word storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[tail_reg] <= push.res0;
        if (push.count == 2'd2)
            mem_reg[tail_plus1] <= push.res1;
    end

    assign head_word    = mem_reg[head_reg];
    assign status.empty = (cnt_reg == '0);
    assign status.room  = (cnt_reg <= fst_pkg::FIFO_CNT_W'(fst_pkg::FIFO_DEPTH - 2));

endmodule

### design/format_string_tokenizer.sv
// Top level of the format string tokenizer: input stage, parser and result queue.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | sink      | in_valid / in_stall   | char_code
//  out     | source    | out_valid / out_stall | token_kind .. error_code, last
//
// One character per cycle is taken while in_stall is low; it is decoded while it sits in the input
// register and the queue has room, and its words are written into the result queue. A character
// that gives two words (short octal escape followed by text) takes two queue entries, and the
// output drains one word a cycle while out_stall is low.
// Reset puts the parser in literal text mode with an empty queue.
// in_stall rises only when the input register holds a character and the four-word
// queue lacks room for two more words.
module format_string_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  token_kind,
    output logic [7:0]  byte_value,
    output logic [7:0]  time_letter,
    output logic [4:0]  flag_mask,
    output logic [15:0] field_width,
    output logic        has_precision,
    output logic [15:0] precision_value,
    output logic [1:0]  value_kind,
    output logic [3:0]  error_code,
    output logic        last
);

    logic                  s1_valid_reg, s1_valid_next;
    logic [7:0]            s1_char_reg;
    logic                  proc;
    logic                  accept;
    logic                  pop;
    fst_pkg::step_out_t    step;
    fst_pkg::result_t      head_word;
    fst_pkg::fifo_status_t fstat;

    // Input stage handshake
    assign proc     = s1_valid_reg && fstat.room;
    assign in_stall = s1_valid_reg && !fstat.room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (proc)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_char_reg <= char_code;
    end

    // Parser
    fst_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (proc),
        .ch    (s1_char_reg),
        .step  (step)
    );

    // Result queue
    assign out_valid = !fstat.empty;
    assign pop       = out_valid && !out_stall;

    fst_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .pop       (pop),
        .head_word (head_word),
        .status    (fstat)
    );

    // Output word fields
    assign token_kind      = head_word.token_kind;
    assign byte_value      = head_word.byte_value;
    assign time_letter     = head_word.time_letter;
    assign flag_mask       = head_word.flag_mask;
    assign field_width     = head_word.field_width;
    assign has_precision   = head_word.has_precision;
    assign precision_value = head_word.precision_value;
    assign value_kind      = head_word.value_kind;
    assign error_code      = head_word.error_code;
    assign last            = head_word.last;

endmodule

### sim/tb_format_string_tokenizer.sv
// Self-checking testbench for the format string tokenizer: directed strings, then random ones.
`timescale 1ns / 1ps

module tb_format_string_tokenizer;

    import fst_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    localparam logic [7:0] END_OF_STRING = 8'h00;

    // Character classes used by the string generator, most of them also by the token predictor
    localparam string FLAG_CHARS   = "#0+ -";
    localparam string DEC_DIGITS   = "0123456789";
    localparam string OCT_DIGITS   = "01234567";
    localparam string ESC_LETTERS  = "abfnrtv\\";
    localparam string TIME_CONVS   = "ABWCT";
    localparam string STR_CONVS    = "abcDfFgGhHikMlnpPstuUwyY";
    localparam string TIME_LETTERS = "%+@aAbBcCdDeFgGhHIjklmMnprRsStTuUVwWxXyYzZ";
    localparam logic [7:0] ESC_VALUES [8] = '{8'd7, 8'd8, 8'd12, 8'd10, 8'd13, 8'd9, 8'd11,
                                             8'd92};

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  char_code = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  token_kind;
    logic [7:0]  byte_value;
    logic [7:0]  time_letter;
    logic [4:0]  flag_mask;
    logic [15:0] field_width;
    logic        has_precision;
    logic [15:0] precision_value;
    logic [1:0]  value_kind;
    logic [3:0]  error_code;
    logic        last;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;

    // Parser state as predicted
    parse_mode_t mode_q      = MODE_LIT;
    logic [7:0]  oct_acc     = 8'h00;
    logic [1:0]  oct_cnt     = 2'd0;
    logic [4:0]  flags_q     = 5'b0;
    logic [15:0] width_q     = 16'h0;
    logic        prec_seen_q = 1'b0;
    logic [15:0] prec_q      = 16'h0;
    logic [7:0]  conv_q      = 8'h00;

    result_t step_tokens[$];
    result_t pending_tokens[$];
    logic [7:0] format_chars[$];

    format_string_tokenizer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .char_code       (char_code),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .token_kind      (token_kind),
        .byte_value      (byte_value),
        .time_letter     (time_letter),
        .flag_mask       (flag_mask),
        .field_width     (field_width),
        .has_precision   (has_precision),
        .precision_value (precision_value),
        .value_kind      (value_kind),
        .error_code      (error_code),
        .last            (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------- token predictor

    function automatic bit char_in(input string chars, input logic [7:0] c);
        for (int i = 0; i < chars.len(); i++)
            if (chars[i] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit is_dec(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    // Decimal digit into a saturating accumulator
    function automatic logic [15:0] add_decimal(input logic [15:0] acc, input logic [7:0] c);
        int v;
        v = int'(acc) * 10 + int'(c[3:0]);
        return (v > int'(SAT_LIMIT)) ? SAT_LIMIT : 16'(v);
    endfunction

    function automatic logic [4:0] flag_of(input logic [7:0] c);
        for (int i = 0; i < FLAG_CHARS.len(); i++)
            if (FLAG_CHARS[i] == c)
                return 5'(1 << i);
        return 5'b0;
    endfunction

    function automatic void push_token(input logic [2:0] kind, input logic [7:0] val,
                                       input logic [7:0] tl, input logic [1:0] vk,
                                       input logic [3:0] err, input bit with_spec);
        result_t t;
        t = '0;
        t.token_kind  = kind;
        t.byte_value  = val;
        t.time_letter = tl;
        t.value_kind  = vk;
        t.error_code  = err;
        if (with_spec)
        begin
            t.flag_mask       = flags_q;
            t.field_width     = width_q;
            t.has_precision   = prec_seen_q;
            t.precision_value = prec_q;
        end
        step_tokens.push_back(t);
    endfunction

    // An error on the terminator ends the string; otherwise the rest is dropped
    function automatic void raise_error(input logic [3:0] code, input logic [7:0] c);
        push_token(TOK_ERROR, 8'h00, 8'h00, VK_STRING, code, 1'b0);
        mode_q = (c == END_OF_STRING) ? MODE_LIT : MODE_ERR;
    endfunction

    function automatic void finish_directive(input logic [7:0] tl, input logic [1:0] vk);
        if (vk == VK_STRING && (flags_q & FLAG_NUMERIC) != 5'b0)
        begin
            raise_error(ERR_NUMERIC_FLAG, 8'h01);
            return;
        end
        push_token(TOK_DIRECTIVE, conv_q, tl, vk, ERR_NONE, 1'b1);
        mode_q = MODE_LIT;
    endfunction

    function automatic void take_conversion(input logic [7:0] c);
        if (c == END_OF_STRING)
        begin
            raise_error(ERR_INC_SPEC, c);
            return;
        end
        conv_q = c;
        if (char_in(TIME_CONVS, c))
            mode_q = MODE_TIME;
        else if (c == "d")
            finish_directive(8'h00, VK_SIGNED);
        else if (c == "m")
            finish_directive(8'h00, VK_OCTAL);
        else if (c == "S")
            finish_directive(8'h00, VK_FLOAT);
        else if (char_in(STR_CONVS, c))
            finish_directive(8'h00, VK_STRING);
        else
            raise_error(ERR_BAD_SPEC, c);
    endfunction

    // Flags, then width, then precision, then the conversion letter
    function automatic void spec_char(input logic [7:0] c);
        logic [4:0] fbit;
        if (mode_q == MODE_FLAG)
        begin
            fbit = flag_of(c);
            if (fbit != 5'b0)
            begin
                if ((flags_q & fbit) != 5'b0)
                    raise_error(ERR_DUP_FLAG, c);
                else
                    flags_q |= fbit;
                return;
            end
            mode_q = MODE_WID;
        end
        if (mode_q == MODE_WID)
        begin
            if (is_dec(c))
                width_q = add_decimal(width_q, c);
            else if (c == ".")
            begin
                prec_seen_q = 1'b1;
                mode_q      = MODE_PREC;
            end
            else
                take_conversion(c);
            return;
        end
        if (is_dec(c))
            prec_q = add_decimal(prec_q, c);
        else
            take_conversion(c);
    endfunction

    function automatic void text_char(input logic [7:0] c);
        if (c == END_OF_STRING)
        begin
            push_token(TOK_END, 8'h00, 8'h00, VK_STRING, ERR_NONE, 1'b0);
            mode_q = MODE_LIT;
        end
        else if (c == "\\")
            mode_q = MODE_ESC;
        else if (c == "%")
            mode_q = MODE_PCT;
        else
        begin
            push_token(TOK_LITERAL, c, 8'h00, VK_STRING, ERR_NONE, 1'b0);
            mode_q = MODE_LIT;
        end
    endfunction

    function automatic void escape_char(input logic [7:0] c);
        if (c >= "0" && c <= "7")
        begin
            oct_acc = {5'b0, c[2:0]};
            oct_cnt = 2'd1;
            mode_q  = MODE_OCT;
            return;
        end
        if (c == "c")
        begin
            push_token(TOK_FLUSH, 8'h00, 8'h00, VK_STRING, ERR_NONE, 1'b0);
            mode_q = MODE_SKIP;
            return;
        end
        if (c == END_OF_STRING)
        begin
            raise_error(ERR_INC_ESCAPE, c);
            return;
        end
        for (int i = 0; i < ESC_LETTERS.len(); i++)
            if (ESC_LETTERS[i] == c)
            begin
                push_token(TOK_LITERAL, ESC_VALUES[i], 8'h00, VK_STRING, ERR_NONE, 1'b0);
                mode_q = MODE_LIT;
                return;
            end
        raise_error(ERR_BAD_ESCAPE, c);
    endfunction

    // Expected words for one accepted character, queued in order
    function automatic void tokenize_char(input logic [7:0] c);
        result_t t;
        step_tokens.delete();
        case (mode_q)
            MODE_ESC:
                escape_char(c);
            MODE_OCT:
                if (c >= "0" && c <= "7" && oct_cnt < 2'd3)
                begin
                    oct_acc = {oct_acc[4:0], c[2:0]};
                    oct_cnt = oct_cnt + 2'd1;
                    if (oct_cnt == 2'd3)
                    begin
                        push_token(TOK_LITERAL, oct_acc, 8'h00, VK_STRING, ERR_NONE, 1'b0);
                        oct_acc = 8'h00;
                        oct_cnt = 2'd0;
                        mode_q  = MODE_LIT;
                    end
                end
                else
                begin
                    // short octal escape: flush it, then treat c as plain text
                    push_token(TOK_LITERAL, oct_acc, 8'h00, VK_STRING, ERR_NONE, 1'b0);
                    oct_acc = 8'h00;
                    oct_cnt = 2'd0;
                    mode_q  = MODE_LIT;
                    text_char(c);
                end
            MODE_PCT:
                if (c == "%")
                begin
                    push_token(TOK_LITERAL, c, 8'h00, VK_STRING, ERR_NONE, 1'b0);
                    mode_q = MODE_LIT;
                end
                else
                begin
                    flags_q     = 5'b0;
                    width_q     = 16'h0;
                    prec_seen_q = 1'b0;
                    prec_q      = 16'h0;
                    conv_q      = 8'h00;
                    mode_q      = MODE_FLAG;
                    spec_char(c);
                end
            MODE_FLAG, MODE_WID, MODE_PREC:
                spec_char(c);
            MODE_TIME:
                if (c == END_OF_STRING)
                    raise_error(ERR_INC_TIME, c);
                else if (char_in(TIME_LETTERS, c))
                    finish_directive(c, VK_STRING);
                else
                    raise_error(ERR_BAD_TIME, c);
            MODE_SKIP:
                if (c == END_OF_STRING)
                begin
                    push_token(TOK_END, 8'h00, 8'h00, VK_STRING, ERR_NONE, 1'b0);
                    mode_q = MODE_LIT;
                end
            MODE_ERR:
                if (c == END_OF_STRING)
                    mode_q = MODE_LIT;
            default:
                text_char(c);
        endcase
        foreach (step_tokens[i])
        begin
            t      = step_tokens[i];
            t.last = (i == step_tokens.size() - 1);
            pending_tokens.push_back(t);
        end
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Compare each output word, then predict for the character taken at this edge
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_tokens.size() == 0)
            begin
                $error("word with none expected: kind %0d byte %0d", token_kind, byte_value);
                fail_count++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                check_field("token_kind", 16'(want.token_kind), 16'(token_kind));
                check_field("byte_value", 16'(want.byte_value), 16'(byte_value));
                check_field("time_letter", 16'(want.time_letter), 16'(time_letter));
                check_field("flag_mask", 16'(want.flag_mask), 16'(flag_mask));
                check_field("field_width", want.field_width, field_width);
                check_field("has_precision", 16'(want.has_precision), 16'(has_precision));
                check_field("precision_value", want.precision_value, precision_value);
                check_field("value_kind", 16'(want.value_kind), 16'(value_kind));
                check_field("error_code", 16'(want.error_code), 16'(error_code));
                check_field("last", 16'(want.last), 16'(last));
            end
        end
        if (rst_n && in_valid && !in_stall)
            tokenize_char(char_code);
    end

    // Receiver back-pressure
    always @(posedge clk)
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);

    // Watchdog on cycles with no word moving on either side
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_char(input logic [7:0] c);
        // each cycle idles with the set chance before the word goes out
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_queued();
        foreach (format_chars[i])
            send_char(format_chars[i]);
    endtask

    // Hold the sender until every expected word has come out
    task automatic wait_for_tokens();
        in_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_from(input string chars);
        return chars[$urandom_range(chars.len() - 1)];
    endfunction

    task automatic add_digits(input int max_n);
        int n;
        n = $urandom_range(1, max_n);
        repeat (n) format_chars.push_back(pick_from(DEC_DIGITS));
    endtask

    // Well-formed directive with random content, now and then a broken one
    task automatic add_directive();
        int conv_pick;
        format_chars.push_back("%");
        for (int i = 0; i < FLAG_CHARS.len(); i++)
            if ($urandom_range(3) == 0)
                format_chars.push_back(FLAG_CHARS[i]);
        if ($urandom_range(19) == 0)
            format_chars.push_back(pick_from(FLAG_CHARS));
        if ($urandom_range(1) == 0)
            add_digits(($urandom_range(7) == 0) ? 6 : 2);
        if ($urandom_range(2) == 0)
        begin
            format_chars.push_back(".");
            if ($urandom_range(3) != 0)
                add_digits(($urandom_range(7) == 0) ? 6 : 2);
        end
        conv_pick = $urandom_range(99);
        if (conv_pick < 15)
            format_chars.push_back("d");
        else if (conv_pick < 25)
            format_chars.push_back("m");
        else if (conv_pick < 35)
            format_chars.push_back("S");
        else if (conv_pick < 65)
            format_chars.push_back(pick_from(STR_CONVS));
        else if (conv_pick < 90)
        begin
            format_chars.push_back(pick_from(TIME_CONVS));
            if ($urandom_range(9) == 0)
                format_chars.push_back(8'($urandom_range(255)));
            else
                format_chars.push_back(pick_from(TIME_LETTERS));
        end
        else
            format_chars.push_back(8'($urandom_range(255)));
    endtask

    task automatic build_random_format();
        int segs;
        int kind_pick;
        format_chars.delete();
        segs = $urandom_range(1, 8);
        repeat (segs)
        begin
            kind_pick = $urandom_range(99);
            if (kind_pick < 28)
                format_chars.push_back(8'($urandom_range(1, 255)));
            else if (kind_pick < 58)
                add_directive();
            else if (kind_pick < 68)
            begin
                format_chars.push_back("\\");
                format_chars.push_back(pick_from(ESC_LETTERS));
            end
            else if (kind_pick < 80)
            begin
                format_chars.push_back("\\");
                repeat ($urandom_range(1, 3)) format_chars.push_back(pick_from(OCT_DIGITS));
            end
            else if (kind_pick < 86)
            begin
                format_chars.push_back("%");
                format_chars.push_back("%");
            end
            else if (kind_pick < 89)
            begin
                format_chars.push_back("\\");
                format_chars.push_back("c");
            end
            else
            begin
                // broken escape or directive, any byte at all after it
                format_chars.push_back(($urandom_range(1) == 0) ? 8'("\\") : 8'("%"));
                format_chars.push_back(8'($urandom_range(255)));
            end
        end
        format_chars.push_back(END_OF_STRING);
    endtask

    // ---------------------------------------------------------------- tests

    // Short octal escape cut by a digit 8, wrap of a three digit escape, top byte value
    task automatic test_octal_then_text();
        send_text("\\18\\777");
        send_char(8'hFF);
        send_char(END_OF_STRING);
    endtask

    // Zero as a flag, width past the saturation limit, empty precision
    task automatic test_saturating_directive();
        send_text("%0#99999.d");
        send_char(END_OF_STRING);
        send_text("%- 7.123456Tz");
        send_char(END_OF_STRING);
    endtask

    // Everything after a flush escape is dropped until the terminator
    task automatic test_flush_tail();
        send_text("\\c%q");
        send_char(END_OF_STRING);
    endtask

    // Terminator inside a directive and inside an escape
    task automatic test_terminator_errors();
        send_text("%");
        send_char(END_OF_STRING);
        send_text("\\");
        send_char(END_OF_STRING);
    endtask

    // Repeated flag, with the rest of the string skipped
    task automatic test_duplicate_flag();
        send_text("%##x");
        send_char(END_OF_STRING);
    endtask

    task automatic test_random_strings(input int char_budget);
        int sent;
        sent = 0;
        while (sent < char_budget)
        begin
            build_random_format();
            send_queued();
            sent += format_chars.size();
        end
        wait_for_tokens();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 28;
        recv_stall_pct = 77;
        test_octal_then_text();
        test_saturating_directive();
        test_flush_tail();
        test_terminator_errors();
        test_duplicate_flag();
        wait_for_tokens();
        test_random_strings(115);

        send_idle_pct  = 77;
        recv_stall_pct = 28;
        test_random_strings(115);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_strings(115);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### format_string_tokenizer.f
design/fst_pkg.sv
design/fst_step.sv
design/fst_out_fifo.sv
design/format_string_tokenizer.sv
sim/tb_format_string_tokenizer.sv
